// ----- hdl/apf_pkg.sv -----
`timescale 1ns / 1ps
package apf_pkg;
  localparam int MaxNodes = 128;
  localparam int MaxEdges = 1024;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int EntryCap = 2 * MaxEdges;
  localparam int EntryW = $clog2(EntryCap) + 1;
  localparam int NumW = 8;
  localparam logic [EntryW-1:0] NilEntry = EntryW'(EntryCap);

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_ANALYZE = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD1, S_ADD2, S_CLR, S_ROOT, S_RCHK, S_PUSH,
    S_TOP, S_TOPW, S_EDGE, S_EDGEW, S_XCHK, S_XW, S_POP, S_POPW, S_POPU,
    S_CNT, S_QRY, S_QRYW, S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic is_cut;
    logic [11:0] degree;
    logic [6:0] cut_count;
  } out_t;
endpackage

// ----- hdl/apf_if.sv -----
`timescale 1ns / 1ps
interface apf_in_if;
  import apf_pkg::*;
  logic valid;
  logic ready;
  in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/apf_out_if.sv -----
`timescale 1ns / 1ps
interface apf_out_if;
  import apf_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/apf_cfg_if.sv -----
`timescale 1ns / 1ps
interface apf_cfg_if;
  logic valid;
  logic ready;
  logic [6:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/apf_ram.sv -----
`timescale 1ns / 1ps
module apf_ram #(
  parameter int Depth = 128,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- hdl/articulation_point_finder.sv -----
`timescale 1ns / 1ps
// Articulation point finder for an undirected graph.
// Channels: in_if (mode, node_a, node_b), out_if (status, is_cut, degree,
// cut_count), cfg_if (node_count write, taken only while idle).
// Each input transfer yields exactly one output transfer.
// Add edge reads head and degree of node_a, writes its entry and reads node_b,
// then writes the entry of node_b; with the edge store full it returns ST_FULL
// and writes nothing. Query reads head and degree of node_a, and an unused mode
// returns an empty result. Analyze clears its flags, then walks the depth-first
// search from each unvisited root number, pushing and popping stack frames,
// then counts the cut flags. Each node and stack memory has one read port.
// One item is in work at a time; input ready is low until the result has
// been taken on the output side, and goes high again on the next cycle.
// Reset empties all adjacency lists, zeroes degrees and cut flags and sets
// node_count to 127. Edge entries, discovery/low numbers and stack frames
// live in memories that are written before they are read.
// A stalled receiver holds the result and blocks further input.
module articulation_point_finder (
  input logic clk_i,
  input logic rst_ni,
  apf_in_if.sink in_if,
  apf_out_if.source out_if,
  apf_cfg_if.sink cfg_if
);
  import apf_pkg::*;

  localparam int EA = EntryW - 1;

  state_e state_q, state_d;
  logic [6:0] ncount_q;
  in_t item_q;
  out_t res_q, res_d;
  logic [EntryW-1:0] ecnt_q, ecnt_d;
  logic [NodeW:0] idx_q, idx_d;
  logic [NumW-1:0] vcnt_q, vcnt_d;
  logic [NodeW:0] sp_q, sp_d;
  logic [NodeW-1:0] v_q, v_d, x_q, x_d, u_q, u_d;
  logic [NumW-1:0] par_q, par_d, ch_q, ch_d, lowv_q, lowv_d;
  logic [EntryW-1:0] cur_q, cur_d;
  logic [6:0] cuts_q, cuts_d;
  logic [MaxNodes-1:0] vis_q, vis_d, cut_q, cut_d;
  logic [MaxNodes-1:0] hval_q, hval_d;

  // node memories: head, degree, disc, low
  logic hd_we; logic [NodeW-1:0] hd_wa, hd_ra; logic [EntryW-1:0] hd_wd, hd_rd;
  logic dg_we; logic [NodeW-1:0] dg_wa, dg_ra; logic [11:0] dg_wd, dg_rd;
  logic ds_we; logic [NodeW-1:0] ds_wa, ds_ra; logic [NumW-1:0] ds_wd, ds_rd;
  logic lw_we; logic [NodeW-1:0] lw_wa, lw_ra; logic [NumW-1:0] lw_wd, lw_rd;
  logic en_we; logic [EA-1:0] en_wa, en_ra;
  logic [EntryW+NodeW-1:0] en_wd, en_rd;
  logic st_we; logic [NodeW-1:0] st_wa, st_ra;
  logic [NodeW+2*NumW+EntryW-1:0] st_wd, st_rd;
  logic [NodeW-1:0] hd_rsel_q;

  apf_ram #(.Depth(MaxNodes), .Width(EntryW)) u_head (.clk_i, .we_i(hd_we),
    .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(hd_ra), .rdata_o(hd_rd));
  apf_ram #(.Depth(MaxNodes), .Width(12)) u_deg (.clk_i, .we_i(dg_we),
    .waddr_i(dg_wa), .wdata_i(dg_wd), .raddr_i(dg_ra), .rdata_o(dg_rd));
  apf_ram #(.Depth(MaxNodes), .Width(NumW)) u_disc (.clk_i, .we_i(ds_we),
    .waddr_i(ds_wa), .wdata_i(ds_wd), .raddr_i(ds_ra), .rdata_o(ds_rd));
  apf_ram #(.Depth(MaxNodes), .Width(NumW)) u_low (.clk_i, .we_i(lw_we),
    .waddr_i(lw_wa), .wdata_i(lw_wd), .raddr_i(lw_ra), .rdata_o(lw_rd));
  apf_ram #(.Depth(EntryCap), .Width(EntryW+NodeW)) u_entry (.clk_i,
    .we_i(en_we), .waddr_i(en_wa), .wdata_i(en_wd), .raddr_i(en_ra),
    .rdata_o(en_rd));
  apf_ram #(.Depth(MaxNodes), .Width(NodeW+2*NumW+EntryW)) u_stack (.clk_i,
    .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd), .raddr_i(st_ra),
    .rdata_o(st_rd));

  always_ff @(posedge clk_i) hd_rsel_q <= hd_ra;

  logic [EntryW-1:0] head_rd;
  assign head_rd = hval_q[hd_rsel_q] ? hd_rd : NilEntry;
  logic [11:0] deg_rd;
  assign deg_rd = hval_q[hd_rsel_q] ? dg_rd : 12'd0;

  logic [NodeW-1:0] s_node; logic [NumW-1:0] s_par, s_ch; logic [EntryW-1:0] s_cur;
  assign {s_node, s_par, s_ch, s_cur} = st_rd;
  logic [EntryW-1:0] e_next; logic [NodeW-1:0] e_tgt;
  assign {e_next, e_tgt} = en_rd;

  logic [6:0] last;
  assign last = (32'(ncount_q) > MaxNodes - 1) ? 7'(MaxNodes - 1) : ncount_q;

  assign in_if.ready = (state_q == S_IDLE);
  assign cfg_if.ready = (state_q == S_IDLE);
  assign out_if.valid = (state_q == S_OUT);
  assign out_if.data = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ncount_q <= 7'd127;
      ecnt_q <= '0;
      vis_q <= '0;
      cut_q <= '0;
      hval_q <= '0;
      vcnt_q <= NumW'(1);
      sp_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_if.valid && cfg_if.ready) ncount_q <= cfg_if.data;
      ecnt_q <= ecnt_d;
      vis_q <= vis_d;
      cut_q <= cut_d;
      hval_q <= hval_d;
      vcnt_q <= vcnt_d;
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) item_q <= in_if.data;
    res_q <= res_d; idx_q <= idx_d; v_q <= v_d; x_q <= x_d; u_q <= u_d;
    par_q <= par_d; ch_q <= ch_d; lowv_q <= lowv_d; cur_q <= cur_d;
    cuts_q <= cuts_d;
  end

  always_comb begin
    state_d = state_q; res_d = res_q; ecnt_d = ecnt_q; idx_d = idx_q;
    vcnt_d = vcnt_q; sp_d = sp_q; v_d = v_q; x_d = x_q; u_d = u_q;
    par_d = par_q; ch_d = ch_q; lowv_d = lowv_q; cur_d = cur_q;
    cuts_d = cuts_q; vis_d = vis_q; cut_d = cut_q; hval_d = hval_q;
    hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
    dg_we = 1'b0; dg_wa = '0; dg_wd = '0; dg_ra = '0;
    ds_we = 1'b0; ds_wa = '0; ds_wd = '0; ds_ra = '0;
    lw_we = 1'b0; lw_wa = '0; lw_wd = '0; lw_ra = '0;
    en_we = 1'b0; en_wa = '0; en_wd = '0; en_ra = '0;
    st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = '0;
    case (state_q)
      S_IDLE: begin
        res_d = '0;
        if (in_if.valid) begin
          case (mode_e'(in_if.data.mode))
            MODE_ADD: begin
              if (32'(ecnt_q) + 2 > EntryCap) begin
                res_d.status = ST_FULL;
                state_d = S_OUT;
              end else begin
                hd_ra = in_if.data.node_a;
                dg_ra = in_if.data.node_a;
                state_d = S_ADD1;
              end
            end
            MODE_ANALYZE: begin
              idx_d = '0; state_d = S_CLR;
            end
            MODE_QUERY: begin
              hd_ra = in_if.data.node_a; dg_ra = in_if.data.node_a;
              state_d = S_QRY;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_ADD1: begin
        en_we = 1'b1; en_wa = ecnt_q[EA-1:0]; en_wd = {head_rd, item_q.node_b};
        hd_we = 1'b1; hd_wa = item_q.node_a; hd_wd = ecnt_q;
        dg_we = 1'b1; dg_wa = item_q.node_a; dg_wd = deg_rd + 12'd1;
        if (item_q.node_a != item_q.node_b) hval_d[item_q.node_a] = 1'b1;
        ecnt_d = ecnt_q + EntryW'(1);
        hd_ra = item_q.node_b; dg_ra = item_q.node_b;
        state_d = S_ADD2;
      end
      S_ADD2: begin
        // read issued before write; forward when both endpoints match
        en_we = 1'b1; en_wa = ecnt_q[EA-1:0];
        en_wd = {(item_q.node_a == item_q.node_b) ? ecnt_q - EntryW'(1) : head_rd,
                 item_q.node_a};
        hd_we = 1'b1; hd_wa = item_q.node_b; hd_wd = ecnt_q;
        dg_we = 1'b1; dg_wa = item_q.node_b;
        dg_wd = ((item_q.node_a == item_q.node_b) ? deg_rd + 12'd1 : deg_rd) + 12'd1;
        hval_d[item_q.node_b] = 1'b1;
        ecnt_d = ecnt_q + EntryW'(1);
        state_d = S_OUT;
      end
      S_CLR: begin
        vis_d = '0; cut_d = '0; vcnt_d = NumW'(1); sp_d = '0;
        idx_d = (NodeW+1)'(1); state_d = S_ROOT;
      end
      S_ROOT: begin
        if (idx_q > (NodeW+1)'(last)) begin
          idx_d = '0; cuts_d = '0; state_d = S_CNT;
        end else begin
          state_d = S_RCHK;
        end
      end
      S_RCHK: begin
        if (vis_q[idx_q[NodeW-1:0]]) begin
          idx_d = idx_q + 1'b1; state_d = S_ROOT;
        end else begin
          x_d = idx_q[NodeW-1:0]; par_d = NumW'(MaxNodes);
          hd_ra = idx_q[NodeW-1:0]; state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        vis_d[x_q] = 1'b1;
        ds_we = 1'b1; ds_wa = x_q; ds_wd = vcnt_q;
        lw_we = 1'b1; lw_wa = x_q; lw_wd = vcnt_q;
        vcnt_d = vcnt_q + 1'b1;
        st_we = 1'b1; st_wa = sp_q[NodeW-1:0];
        st_wd = {x_q, par_q, NumW'(0), head_rd};
        sp_d = sp_q + 1'b1;
        state_d = S_TOP;
      end
      S_TOP: begin
        if (sp_q == '0) begin
          idx_d = idx_q + 1'b1; state_d = S_ROOT;
        end else begin
          st_ra = sp_q[NodeW-1:0] - 1'b1; state_d = S_TOPW;
        end
      end
      S_TOPW: begin
        v_d = s_node; par_d = s_par; ch_d = s_ch; cur_d = s_cur;
        lw_ra = s_node;
        if (s_cur < NilEntry) begin
          en_ra = s_cur[EA-1:0]; state_d = S_EDGE;
        end else begin
          state_d = S_POP;
        end
      end
      S_EDGE: begin
        lowv_d = lw_rd;
        x_d = e_tgt;
        cur_d = e_next;
        if (NumW'(e_tgt) == par_q) begin
          st_we = 1'b1; st_wa = sp_q[NodeW-1:0] - 1'b1;
          st_wd = {v_q, par_q, ch_q, e_next};
          state_d = S_TOP;
        end else if (!vis_q[e_tgt]) begin
          st_we = 1'b1; st_wa = sp_q[NodeW-1:0] - 1'b1;
          st_wd = {v_q, par_q, ch_q + 1'b1, e_next};
          par_d = NumW'(v_q);
          hd_ra = e_tgt; state_d = S_PUSH;
        end else begin
          st_we = 1'b1; st_wa = sp_q[NodeW-1:0] - 1'b1;
          st_wd = {v_q, par_q, ch_q, e_next};
          ds_ra = e_tgt; state_d = S_XCHK;
        end
      end
      S_XCHK: begin
        if (ds_rd < lowv_q) begin
          lw_we = 1'b1; lw_wa = v_q; lw_wd = ds_rd;
        end
        state_d = S_TOP;
      end
      S_POP: begin
        lowv_d = lw_rd;
        sp_d = sp_q - 1'b1;
        if (sp_q == (NodeW+1)'(1)) begin
          state_d = S_TOP;
        end else begin
          st_ra = sp_q[NodeW-1:0] - 2'd2; state_d = S_POPW;
        end
      end
      S_POPW: begin
        u_d = s_node; ch_d = s_ch;
        lw_ra = s_node; ds_ra = s_node;
        state_d = S_POPU;
      end
      S_POPU: begin
        if (lowv_q < lw_rd) begin
          lw_we = 1'b1; lw_wa = u_q; lw_wd = lowv_q;
        end
        if (sp_q == (NodeW+1)'(1)) begin
          if (ch_q > NumW'(1)) cut_d[u_q] = 1'b1;
        end else if (lowv_q >= ds_rd) begin
          cut_d[u_q] = 1'b1;
        end
        state_d = S_TOP;
      end
      S_CNT: begin
        cuts_d = cuts_q + 7'(cut_q[idx_q[NodeW-1:0]]);
        idx_d = idx_q + 1'b1;
        if (idx_q == (NodeW+1)'(MaxNodes - 1)) begin
          res_d.cut_count = cuts_q + 7'(cut_q[idx_q[NodeW-1:0]]);
          state_d = S_OUT;
        end
      end
      S_QRY: begin
        res_d.is_cut = cut_q[item_q.node_a];
        res_d.degree = deg_rd;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_if.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import apf_pkg::*;

  logic clk_i;
  logic rst_ni;

  apf_in_if in_if ();
  apf_out_if out_if ();
  apf_cfg_if cfg_if ();

  articulation_point_finder u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if.sink),
    .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  localparam int CycleLimit = 6000000;
  localparam int NoParent = MaxNodes;

  // graph mirror
  logic [6:0] gr_node_count;
  logic [EntryW-1:0] gr_head [MaxNodes];
  logic [EntryW-1:0] gr_next [EntryCap];
  logic [NodeW-1:0] gr_target [EntryCap];
  int gr_entries;
  logic [11:0] gr_degree [MaxNodes];
  bit gr_seen [MaxNodes];
  logic [NumW-1:0] gr_disc [MaxNodes];
  logic [NumW-1:0] gr_low [MaxNodes];
  bit gr_cut [MaxNodes];
  int gr_clock;
  int fr_node [MaxNodes];
  int fr_parent [MaxNodes];
  int fr_cursor [MaxNodes];
  int fr_kids [MaxNodes];
  int fr_depth;

  out_t want_q[$];
  int errors;
  int cycles;
  bit calm;
  bit hold_req;

  task automatic report(string what, int got, int exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic void graph_reset();
    gr_node_count = 7'd127;
    for (int i = 0; i < MaxNodes; i++) begin
      gr_head[i] = NilEntry;
      gr_degree[i] = '0;
      gr_seen[i] = 0;
      gr_cut[i] = 0;
    end
    gr_entries = 0;
    gr_clock = 1;
    fr_depth = 0;
  endfunction

  function automatic void link(int from, int to);
    gr_target[gr_entries] = NodeW'(to);
    gr_next[gr_entries] = gr_head[from];
    gr_head[from] = EntryW'(gr_entries);
    gr_entries++;
    gr_degree[from] = gr_degree[from] + 12'd1;
  endfunction

  function automatic void open_frame(int v, int parent);
    gr_seen[v] = 1;
    gr_disc[v] = NumW'(gr_clock);
    gr_low[v] = NumW'(gr_clock);
    gr_clock++;
    fr_node[fr_depth] = v;
    fr_parent[fr_depth] = parent;
    fr_cursor[fr_depth] = int'(gr_head[v]);
    fr_kids[fr_depth] = 0;
    fr_depth++;
  endfunction

  function automatic void search_tree(int root);
    int t, v, e, x, p, u;
    open_frame(root, NoParent);
    while (fr_depth > 0) begin
      t = fr_depth - 1;
      v = fr_node[t];
      e = fr_cursor[t];
      if (e < EntryCap) begin
        x = int'(gr_target[e]);
        fr_cursor[t] = int'(gr_next[e]);
        if (x == fr_parent[t]) continue;
        if (!gr_seen[x]) begin
          fr_kids[t]++;
          open_frame(x, v);
        end else if (gr_disc[x] < gr_low[v]) begin
          gr_low[v] = gr_disc[x];
        end
      end else begin
        fr_depth--;
        if (fr_depth > 0) begin
          p = fr_depth - 1;
          u = fr_node[p];
          if (gr_low[v] < gr_low[u]) gr_low[u] = gr_low[v];
          if (p == 0) begin
            if (fr_kids[p] > 1) gr_cut[u] = 1;
          end else if (gr_low[v] >= gr_disc[u]) begin
            gr_cut[u] = 1;
          end
        end
      end
    end
  endfunction

  function automatic out_t graph_step(in_t it);
    out_t r;
    int n;
    r = '0;
    case (mode_e'(it.mode))
      MODE_ADD: begin
        if (gr_entries + 2 > EntryCap) begin
          r.status = ST_FULL;
        end else begin
          link(it.node_a, it.node_b);
          link(it.node_b, it.node_a);
        end
      end
      MODE_ANALYZE: begin
        for (int i = 0; i < MaxNodes; i++) begin
          gr_seen[i] = 0;
          gr_cut[i] = 0;
        end
        gr_clock = 1;
        fr_depth = 0;
        for (int i = 1; i <= int'(gr_node_count) && i < MaxNodes; i++)
          if (!gr_seen[i]) search_tree(i);
        n = 0;
        for (int i = 0; i < MaxNodes; i++) if (gr_cut[i]) n++;
        r.cut_count = 7'(n);
      end
      MODE_QUERY: begin
        r.is_cut = gr_cut[it.node_a];
        r.degree = gr_degree[it.node_a];
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_t got, exp;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (want_q.size() == 0) begin
        report("unexpected transfer", 0, 0);
      end else begin
        exp = want_q.pop_front();
        if (got.status !== exp.status) report("status", got.status, exp.status);
        if (got.is_cut !== exp.is_cut) report("is_cut", got.is_cut, exp.is_cut);
        if (got.degree !== exp.degree) report("degree", got.degree, exp.degree);
        if (got.cut_count !== exp.cut_count)
          report("cut_count", got.cut_count, exp.cut_count);
      end
    end
  end

  initial begin
    int n;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (600) @(negedge clk_i);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 9) < 3) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        out_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(in_t it, bit typed, out_t want);
    out_t pred;
    int gap;
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    pred = graph_step(it);
    want_q = {want_q, typed ? want : pred};
    gap = 0;
    if (!calm) begin
      n_gap: begin
        int r;
        r = $urandom_range(0, 99);
        if (r >= 95) gap = $urandom_range(10, 40);
        else if (r >= 75) gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    wait (want_q.size() == 0);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_node_count(logic [6:0] v);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    gr_node_count = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic in_t pick_item(int base, int span);
    in_t it;
    int r;
    r = $urandom_range(0, 99);
    it.mode = (r < 64) ? MODE_ADD : (r < 94) ? MODE_QUERY : (r < 97) ? MODE_ANALYZE : MODE_NONE;
    if ($urandom_range(0, 9) == 0) begin
      it.node_a = NodeW'($urandom_range(0, MaxNodes - 1));
      it.node_b = NodeW'($urandom_range(0, MaxNodes - 1));
    end else begin
      it.node_a = NodeW'(base + $urandom_range(0, span));
      it.node_b = ($urandom_range(0, 30) == 0) ? it.node_a :
                  NodeW'(int'(it.node_a) + $urandom_range(0, 4) - 2);
    end
    return it;
  endfunction

  typedef struct {
    mode_e mode;
    int a;
    int b;
    bit typed;
    out_t want;
  } row_t;

  row_t rows[] = '{
    '{MODE_QUERY, 0, 0, 1, '0},
    '{MODE_QUERY, 127, 0, 1, '0},
    '{MODE_ANALYZE, 0, 0, 1, '0},
    '{MODE_NONE, 127, 127, 1, '0},
    '{MODE_ADD, 0, 127, 1, '0},
    '{MODE_ADD, 5, 5, 1, '0},
    '{MODE_QUERY, 5, 0, 1, '{status: ST_OK, is_cut: 0, degree: 12'd2, cut_count: 0}},
    '{MODE_ADD, 1, 2, 0, '0},
    '{MODE_ADD, 2, 3, 0, '0},
    '{MODE_ADD, 2, 3, 0, '0},
    '{MODE_ADD, 3, 4, 0, '0},
    '{MODE_ADD, 127, 1, 0, '0},
    '{MODE_ADD, 10, 11, 0, '0},
    '{MODE_ADD, 10, 12, 0, '0},
    '{MODE_ANALYZE, 0, 0, 0, '0},
    '{MODE_QUERY, 2, 0, 0, '0},
    '{MODE_QUERY, 3, 0, 0, '0},
    '{MODE_QUERY, 10, 0, 0, '0},
    '{MODE_QUERY, 127, 0, 0, '0},
    '{MODE_QUERY, 0, 0, 0, '0},
    '{MODE_NONE, 0, 0, 1, '0}
  };

  initial begin
    in_t it;
    int base, span, lens;
    logic [6:0] counts[8];
    counts = '{7'd1, 7'd127, 7'd0, 7'd64, 7'd127, 7'd20, 7'd127, 7'd127};
    errors = 0;
    cycles = 0;
    calm = 0;
    hold_req = 0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    graph_reset();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      it.mode = rows[i].mode;
      it.node_a = NodeW'(rows[i].a);
      it.node_b = NodeW'(rows[i].b);
      send_item(it, rows[i].typed, rows[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_node_count(ph == 3 ? 7'($urandom_range(1, 126)) : counts[ph]);
      calm = (ph == 4);
      base = $urandom_range(0, 110);
      span = $urandom_range(4, 16);
      lens = 200;
      for (int k = 0; k < lens; k++) begin
        if (ph == 2 && k == 20) hold_req = 1;
        if (ph == 5 && k == 50) wait (want_q.size() == 0);
        if (k % 40 == 39) begin
          base = $urandom_range(0, 110);
          span = $urandom_range(4, 16);
        end
        send_item(pick_item(base, span), 0, '0);
      end
    end
    calm = 0;

    while (gr_entries + 2 <= EntryCap) begin
      it.mode = MODE_ADD;
      it.node_a = NodeW'($urandom_range(0, MaxNodes - 1));
      it.node_b = NodeW'($urandom_range(0, MaxNodes - 1));
      send_item(it, 0, '0);
    end
    for (int k = 0; k < 30; k++) send_item(pick_item(0, 127), 0, '0);
    it.mode = MODE_ADD;
    it.node_a = NodeW'(127);
    it.node_b = NodeW'(0);
    send_item(it, 1, '{status: ST_FULL, is_cut: 0, degree: 0, cut_count: 0});
    it.mode = MODE_ANALYZE;
    send_item(it, 0, '0);

    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
